// ===== rtl/psrrq_pkg.sv =====
// Shared constants and types of the per-source round-robin queue scheduler.
`default_nettype none

package psrrq_pkg;

   localparam int MAX_SOURCES    = 8;
   localparam int QUEUE_DEPTH    = 16;
   localparam int CMD_FIFO_DEPTH = 2;

   localparam int SRC_W  = 16;
   localparam int PKT_W  = 32;
   localparam int QOUT_W = 3;
   localparam int SLOT_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int USED_W = $clog2(MAX_SOURCES + 1);
   localparam int HEAD_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(MAX_SOURCES * QUEUE_DEPTH);

   localparam int REQ_TDATA_W = ((SRC_W + PKT_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((PKT_W + QOUT_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               table_full;
      logic [SLOT_W-1:0]  slot;
      logic [USED_W-1:0]  used;
      logic [PKT_W-1:0]   pkt;
   } sched_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/per_source_round_robin_queues.sv =====
// Top level of the per-source round-robin packet queue scheduler.
//
//   Channel | Direction | tdata (low bit up)             | tuser (low bit up)
//   req_    | in        | source_id[15:0], packet_ref    | cmd
//   rsp_    | out       | out_packet[31:0], out_queue    | out_valid, dropped
//
// One transfer per cycle is sustained while rsp_tready is high; each request yields
// exactly one response, via command queue write at the accepting edge, back update
// and store read, then result register. Synchronous active-high reset clears slot
// table count, fills and heads; the round-robin pointer resets to the last slot.
// A stalled response backs up through the command queue into req_tready.
`default_nettype none

module per_source_round_robin_queues (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [psrrq_pkg::REQ_TDATA_W-1:0]     req_tdata,  // source_id, packet_ref
   input  wire                                  req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [psrrq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // out_packet, out_queue
   output logic [psrrq_pkg::RSP_TUSER_W-1:0]    rsp_tuser   // out_valid, dropped
);
   import psrrq_pkg::*;

   sched_cmd_type     push_cmd;
   sched_cmd_type     pop_cmd;
   logic              push;
   logic              pop;
   logic              fifo_full;
   logic              fifo_empty;
   cmd_type           in_cmd;
   logic              rsp_hit;
   logic              rsp_drop;
   logic [PKT_W-1:0]  rsp_packet;
   logic [QOUT_W-1:0] rsp_queue;

   assign in_cmd = cmd_type'(req_tuser);

   psrrq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (in_cmd),
      .in_src   (req_tdata[SRC_W-1:0]),
      .in_pkt   (req_tdata[SRC_W+PKT_W-1:SRC_W]),
      .fifo_full(fifo_full),
      .push     (push),
      .cmd_out  (push_cmd)
   );

   psrrq_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .pop_data (pop_cmd),
      .empty    (fifo_empty)
   );

   psrrq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .fifo_empty(fifo_empty),
      .cmd       (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_hit   (rsp_hit),
      .rsp_packet(rsp_packet),
      .rsp_queue (rsp_queue),
      .rsp_drop  (rsp_drop)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp_queue, rsp_packet});
   assign rsp_tuser = {rsp_drop, rsp_hit};

endmodule

`default_nettype wire

// ===== rtl/psrrq_front.sv =====
// Front end: source table lookup, slot allocation and command generation.
`default_nettype none

module psrrq_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  psrrq_pkg::cmd_type          in_cmd,
   input  wire [psrrq_pkg::SRC_W-1:0]  in_src,
   input  wire [psrrq_pkg::PKT_W-1:0]  in_pkt,
   input  wire                         fifo_full,
   output logic                        push,
   output psrrq_pkg::sched_cmd_type    cmd_out
);
   import psrrq_pkg::*;

   logic [SRC_W-1:0]  table_ff [MAX_SOURCES];
   logic [USED_W-1:0] used_ff;
   logic [USED_W-1:0] used_in;
   logic              hit;
   logic [SLOT_W-1:0] hit_slot;
   logic              full;
   logic              alloc;

   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
         if ((USED_W'(i) < used_ff) && (table_ff[i] == in_src)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   assign in_ready = !fifo_full;
   assign push     = in_valid && !fifo_full;
   assign full     = (used_ff == USED_W'(MAX_SOURCES));
   assign alloc    = push && (in_cmd == CMD_ENQ) && !hit && !full;
   assign used_in  = alloc ? used_ff + USED_W'(1) : used_ff;

   always_comb begin
      cmd_out.cmd        = in_cmd;
      cmd_out.table_full = !hit && full;
      cmd_out.slot       = hit ? hit_slot : used_ff[SLOT_W-1:0];
      cmd_out.used       = used_in;
      cmd_out.pkt        = in_pkt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         table_ff[used_ff[SLOT_W-1:0]] <= in_src;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psrrq_cmd_fifo.sv =====
// Short command queue between front end and back end.
`default_nettype none

module psrrq_cmd_fifo (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  psrrq_pkg::sched_cmd_type   push_data,
   output logic                       full,
   input  wire                        pop,
   output psrrq_pkg::sched_cmd_type   pop_data,
   output logic                       empty
);
   import psrrq_pkg::*;

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   sched_cmd_type    entry_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(CMD_FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psrrq_back.sv =====
// Back end: per-slot FIFOs in a shared store, round-robin dequeue, result register.
`default_nettype none

module psrrq_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          fifo_empty,
   input  psrrq_pkg::sched_cmd_type     cmd,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_hit,
   output logic [psrrq_pkg::PKT_W-1:0]  rsp_packet,
   output logic [psrrq_pkg::QOUT_W-1:0] rsp_queue,
   output logic                         rsp_drop
);
   import psrrq_pkg::*;

   localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);

   logic [PKT_W-1:0]  mem [MAX_SOURCES * QUEUE_DEPTH];
   logic [PKT_W-1:0]  rd_ff;
   logic [FILL_W-1:0] fill_ff [MAX_SOURCES];
   logic [HEAD_W-1:0] head_ff [MAX_SOURCES];
   logic [SLOT_W-1:0] rr_ff;

   logic              pend_ff;
   logic              pend_hit_ff;
   logic [QOUT_W-1:0] pend_queue_ff;
   logic              pend_drop_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [PKT_W-1:0]  rsp_packet_ff;
   logic [QOUT_W-1:0] rsp_queue_ff;
   logic              rsp_drop_ff;

   logic              move;
   logic              is_deq;
   logic [USED_W-1:0] start;
   logic [USED_W-1:0] rr_plus;
   logic              any_ne;
   logic              found_hi;
   logic [SLOT_W-1:0] sel_hi;
   logic [SLOT_W-1:0] sel_lo;
   logic [SLOT_W-1:0] idx;
   logic [FILL_W-1:0] fill_sel;
   logic [HEAD_W-1:0] head_sel;
   logic              queue_full;
   logic [SUM_W-1:0]  pos_sum;
   logic [HEAD_W-1:0] pos;
   logic [ADDR_W-1:0] addr;
   logic              enq_ok;
   logic              deq_ok;
   logic [HEAD_W-1:0] head_inc;

   assign move   = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign pop    = !fifo_empty && (!pend_ff || move);
   assign is_deq = (cmd.cmd == CMD_DEQ);

   assign rr_plus = USED_W'(rr_ff) + USED_W'(1);
   assign start   = (rr_plus >= cmd.used) ? '0 : rr_plus;

   always_comb begin
      any_ne   = 1'b0;
      found_hi = 1'b0;
      sel_hi   = '0;
      sel_lo   = '0;
      for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
         if (fill_ff[i] != '0) begin
            any_ne = 1'b1;
            sel_lo = SLOT_W'(i);
            if (USED_W'(i) >= start) begin
               found_hi = 1'b1;
               sel_hi   = SLOT_W'(i);
            end
         end
      end
   end

   assign idx        = is_deq ? (found_hi ? sel_hi : sel_lo) : cmd.slot;
   assign fill_sel   = fill_ff[idx];
   assign head_sel   = head_ff[idx];
   assign queue_full = (fill_sel == FILL_W'(QUEUE_DEPTH));
   assign pos_sum    = SUM_W'(head_sel) + SUM_W'(fill_sel);
   assign pos        = (pos_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       HEAD_W'(pos_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(pos_sum);
   assign head_inc   = (head_sel == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + HEAD_W'(1);
   assign addr       = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) +
                       ADDR_W'(is_deq ? head_sel : pos);
   assign enq_ok     = pop && !is_deq && !cmd.table_full && !queue_full;
   assign deq_ok     = pop && is_deq && any_ne;

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         mem[addr] <= cmd.pkt;
      end
      if (deq_ok) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SOURCES; i++) begin
            fill_ff[i] <= '0;
            head_ff[i] <= '0;
         end
         rr_ff        <= SLOT_W'(MAX_SOURCES - 1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (enq_ok) begin
            fill_ff[idx] <= fill_sel + FILL_W'(1);
         end
         if (deq_ok) begin
            fill_ff[idx] <= fill_sel - FILL_W'(1);
            head_ff[idx] <= head_inc;
            rr_ff        <= idx;
         end
         if (pop) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pend_hit_ff   <= deq_ok;
         pend_drop_ff  <= !is_deq && (cmd.table_full || queue_full);
         pend_queue_ff <= ((!is_deq && !cmd.table_full) || deq_ok) ? QOUT_W'(idx) : '0;
      end
      if (move) begin
         rsp_hit_ff    <= pend_hit_ff;
         rsp_drop_ff   <= pend_drop_ff;
         rsp_queue_ff  <= pend_queue_ff;
         rsp_packet_ff <= pend_hit_ff ? rd_ff : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_packet = rsp_packet_ff;
   assign rsp_queue  = rsp_queue_ff;
   assign rsp_drop   = rsp_drop_ff;

endmodule

`default_nettype wire

// ===== rtl/psrrq_checker.sv =====
// Port-level checks for the scheduler top level, bound to it.
`default_nettype none

module psrrq_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [psrrq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input wire [psrrq_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);
   import psrrq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_hit_not_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("dequeued packet flagged as dropped");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[PKT_W-1:0] == '0)
      else $error("packet field nonzero without a dequeued packet");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind per_source_round_robin_queues psrrq_checker u_psrrq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
